// ===== rtl/step_guider_position_and_calibration_macros.svh =====
// Assertion macros for the step guider RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef STEP_GUIDER_POSITION_AND_CALIBRATION_MACROS_SVH
`define STEP_GUIDER_POSITION_AND_CALIBRATION_MACROS_SVH

// same-cycle implication, disabled in reset
`define SGPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define SGPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sgpc_pkg.sv =====
// Types, codes and reset constants of the step guider position/calibration block.
// Depends on nothing.
`default_nettype none

package sgpc_pkg;

	localparam int POS_BITS_DEFAULT = 13;
	localparam int POS_OUT_W        = 13;
	localparam int MAX_W            = 12;
	localparam int SPI_W            = 14;
	localparam int AMT_W            = 16;
	localparam int CNT_W            = 16;
	localparam int ADDR_W           = 5;
	localparam int DATA_W           = 32;

	localparam logic [SPI_W-1:0] SPI_RESET  = 14'd4;
	localparam logic [MAX_W-1:0] STEPS_SAT  = 12'hFFF;

	typedef enum logic [1:0] {
		OP_MOVE      = 2'd0,
		OP_CENTER    = 2'd1,
		OP_CAL_BEGIN = 2'd2,
		OP_CAL_UPD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DIR_NORTH = 2'd0,
		DIR_SOUTH = 2'd1,
		DIR_EAST  = 2'd2,
		DIR_WEST  = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_LIMIT   = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_CLEAR    = 3'd0,
		PH_CORNER   = 3'd1,
		PH_WEST     = 3'd2,
		PH_NORTH    = 3'd3,
		PH_RECENTER = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		REG_GUIDING_EN = 3'd0,
		REG_DEV_CONN   = 3'd1,
		REG_SPI        = 3'd2,
		REG_MAX_NORTH  = 3'd3,
		REG_MAX_SOUTH  = 3'd4,
		REG_MAX_EAST   = 3'd5,
		REG_MAX_WEST   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic             guiding_enabled;
		logic             device_connected;
		logic [SPI_W-1:0] steps_per_iteration;
		logic [MAX_W-1:0] max_north;
		logic [MAX_W-1:0] max_south;
		logic [MAX_W-1:0] max_east;
		logic [MAX_W-1:0] max_west;
	} cfg_t;

	typedef struct packed {
		op_t              operation;
		dir_t             direction;
		logic [AMT_W-1:0] amount;
		logic             normal_move;
		logic             secondary_ready;
		logic             position_valid;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [MAX_W-1:0]     steps_taken;
		logic [POS_OUT_W-1:0] x_position;
		logic [POS_OUT_W-1:0] y_position;
		logic                 move_north;
		logic                 move_south;
		logic                 move_east;
		logic                 move_west;
		logic                 calibrated;
		logic [1:0]           leg_finished;
		logic [CNT_W-1:0]     leg_iterations;
		logic                 offload_request;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/sgpc_regs.sv =====
// APB-style configuration register file of the step guider block.
// Depends on sgpc_pkg.
`default_nettype none

module sgpc_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sgpc_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [sgpc_pkg::DATA_W-1:0]  pwdata,
	output logic      [sgpc_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	output sgpc_pkg::cfg_t                    cfg
);
	import sgpc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.guiding_enabled     <= 1'b1;
			cfg_q.device_connected    <= 1'b0;
			cfg_q.steps_per_iteration <= SPI_RESET;
			cfg_q.max_north           <= '0;
			cfg_q.max_south           <= '0;
			cfg_q.max_east            <= '0;
			cfg_q.max_west            <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_GUIDING_EN: cfg_q.guiding_enabled     <= pwdata[0];
				REG_DEV_CONN:   cfg_q.device_connected    <= pwdata[0];
				REG_SPI:        cfg_q.steps_per_iteration <= pwdata[SPI_W-1:0];
				REG_MAX_NORTH:  cfg_q.max_north           <= pwdata[MAX_W-1:0];
				REG_MAX_SOUTH:  cfg_q.max_south           <= pwdata[MAX_W-1:0];
				REG_MAX_EAST:   cfg_q.max_east            <= pwdata[MAX_W-1:0];
				REG_MAX_WEST:   cfg_q.max_west            <= pwdata[MAX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_GUIDING_EN: prdata = DATA_W'(cfg_q.guiding_enabled);
			REG_DEV_CONN:   prdata = DATA_W'(cfg_q.device_connected);
			REG_SPI:        prdata = DATA_W'(cfg_q.steps_per_iteration);
			REG_MAX_NORTH:  prdata = DATA_W'(cfg_q.max_north);
			REG_MAX_SOUTH:  prdata = DATA_W'(cfg_q.max_south);
			REG_MAX_EAST:   prdata = DATA_W'(cfg_q.max_east);
			REG_MAX_WEST:   prdata = DATA_W'(cfg_q.max_west);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/sgpc_core.sv =====
// Position/calibration state and the single-pass logic that serves one request.
// Depends on sgpc_pkg.
`default_nettype none

module sgpc_core #(
	parameter int POS_BITS = sgpc_pkg::POS_BITS_DEFAULT
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  sgpc_pkg::req_t      req,
	input  sgpc_pkg::cfg_t      cfg,
	output sgpc_pkg::rsp_t      rsp
);
	import sgpc_pkg::*;

	// signed compare width: holds negated offsets, limits, thresholds and 4x position
	localparam int CW = ((POS_BITS > SPI_W) ? POS_BITS : SPI_W) + 4;

	logic [POS_BITS-1:0] x_q, y_q, x_n, y_n;
	phase_t              phase_q, phase_n;
	logic [CNT_W-1:0]    count_q, count_n;
	logic                done_q, done_n;

	function automatic logic signed [CW-1:0] sx(input logic [POS_BITS-1:0] v);
		sx = signed'({{(CW-POS_BITS){v[POS_BITS-1]}}, v});
	endfunction

	function automatic logic signed [CW-1:0] ux(input logic [SPI_W-1:0] v);
		ux = signed'(CW'(v));
	endfunction

	function automatic logic signed [CW-1:0] pos_of(input dir_t d,
		input logic [POS_BITS-1:0] x, input logic [POS_BITS-1:0] y);
		unique case (d)
			DIR_NORTH: pos_of = sx(y);
			DIR_SOUTH: pos_of = -sx(y);
			DIR_EAST:  pos_of = sx(x);
			DIR_WEST:  pos_of = -sx(x);
			default:   pos_of = '0;
		endcase
	endfunction

	function automatic logic signed [CW-1:0] max_of(input dir_t d, input cfg_t c);
		unique case (d)
			DIR_NORTH: max_of = ux(SPI_W'(c.max_north));
			DIR_SOUTH: max_of = ux(SPI_W'(c.max_south));
			DIR_EAST:  max_of = ux(SPI_W'(c.max_east));
			DIR_WEST:  max_of = ux(SPI_W'(c.max_west));
			default:   max_of = '0;
		endcase
	endfunction

	logic [MAX_W:0]        rnd;
	logic [MAX_W-1:0]      steps;
	logic signed [CW-1:0]  spi, pos_d, max_d;
	logic                  hit, s_ok, e_ok, w_ok, n_ok, rc_e, rc_s;

	assign rnd   = (MAX_W+1)'((17'(req.amount) + 17'd8) >> 4);
	assign steps = rnd[MAX_W] ? STEPS_SAT : rnd[MAX_W-1:0];
	assign spi   = ux((cfg.steps_per_iteration == '0) ? SPI_RESET : cfg.steps_per_iteration);
	assign pos_d = pos_of(req.direction, x_q, y_q);
	assign max_d = max_of(req.direction, cfg);
	assign hit   = (pos_d + ux(SPI_W'(steps))) >= max_d;

	assign s_ok = (max_of(DIR_SOUTH, cfg) - pos_of(DIR_SOUTH, x_q, y_q)) >= spi;
	assign e_ok = (max_of(DIR_EAST, cfg) - pos_of(DIR_EAST, x_q, y_q)) >= spi;
	assign w_ok = (max_of(DIR_WEST, cfg) - pos_of(DIR_WEST, x_q, y_q)) >= spi;
	assign n_ok = (max_of(DIR_NORTH, cfg) - pos_of(DIR_NORTH, x_q, y_q)) >= spi;
	assign rc_e = pos_of(DIR_WEST, x_q, y_q) >= spi;
	assign rc_s = pos_of(DIR_NORTH, x_q, y_q) >= spi;

	always_comb begin
		logic held;
		held    = 1'b0;
		x_n     = x_q;
		y_n     = y_q;
		phase_n = phase_q;
		count_n = count_q;
		done_n  = done_q;
		rsp     = '0;
		unique case (req.operation)
			OP_MOVE: begin
				if (cfg.guiding_enabled && steps != '0) begin
					if (hit) begin
						rsp.status = ST_LIMIT;
					end else begin
						rsp.steps_taken = steps;
						unique case (req.direction)
							DIR_NORTH: y_n = y_q + POS_BITS'(steps);
							DIR_SOUTH: y_n = y_q - POS_BITS'(steps);
							DIR_EAST:  x_n = x_q + POS_BITS'(steps);
							DIR_WEST:  x_n = x_q - POS_BITS'(steps);
							default: ;
						endcase
					end
				end
			end
			OP_CENTER: begin
				x_n = '0;
				y_n = '0;
			end
			OP_CAL_BEGIN: begin
				if (!cfg.device_connected || !req.position_valid) begin
					rsp.status = ST_REFUSED;
				end else begin
					phase_n = PH_CORNER;
					count_n = '0;
					done_n  = 1'b0;
				end
			end
			OP_CAL_UPD: begin
				if (phase_q == PH_CORNER || phase_q == PH_WEST || phase_q == PH_NORTH ||
					phase_q == PH_RECENTER) begin
					if (phase_n == PH_CORNER) begin
						if (s_ok || e_ok) begin
							rsp.move_south = s_ok;
							rsp.move_east  = e_ok;
							held = 1'b1;
						end else begin
							phase_n = PH_WEST;
							count_n = '0;
						end
					end
					if (!held && phase_n == PH_WEST) begin
						if (w_ok) begin
							count_n = count_n + 1'b1;
							rsp.move_west = 1'b1;
							held = 1'b1;
						end else begin
							rsp.leg_finished[0] = 1'b1;
							rsp.leg_iterations  = count_n;
							count_n = '0;
							phase_n = PH_NORTH;
						end
					end
					if (!held && phase_n == PH_NORTH) begin
						if (n_ok) begin
							count_n = count_n + 1'b1;
							rsp.move_north = 1'b1;
							held = 1'b1;
						end else begin
							rsp.leg_finished[1] = 1'b1;
							rsp.leg_iterations  = count_n;
							count_n = '0;
							phase_n = PH_RECENTER;
						end
					end
					if (!held && phase_n == PH_RECENTER) begin
						rsp.move_east  = rc_e;
						rsp.move_south = rc_s;
					end
					if (!rsp.move_north && !rsp.move_south && !rsp.move_east &&
						!rsp.move_west) begin
						done_n = 1'b1;
					end
				end
			end
			default: ;
		endcase
		// offload test: pos > (75*max)/100  <=>  4*pos > 3*max for integer pos
		if (req.operation == OP_MOVE && req.normal_move && req.secondary_ready &&
			((pos_of(req.direction, x_n, y_n) <<< 2) > (max_d + (max_d <<< 1)))) begin
			rsp.offload_request = 1'b1;
		end
		rsp.x_position = POS_OUT_W'(x_n);
		rsp.y_position = POS_OUT_W'(y_n);
		rsp.calibrated = done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			phase_q <= PH_CLEAR;
			count_q <= '0;
			done_q  <= 1'b0;
		end else if (adv) begin
			x_q     <= x_n;
			y_q     <= y_n;
			phase_q <= phase_n;
			count_q <= count_n;
			done_q  <= done_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/step_guider_position_and_calibration.sv =====
// Top level of the step guider position tracker and calibration sequencer.
// Depends on sgpc_pkg, sgpc_regs, sgpc_core and the assertion macro header.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------------------------
//   request  | in_valid / in_stall          | operation direction amount normal_move ...
//   result   | out_valid / out_stall        | status steps_taken x/y_position move_* ...
//   config   | psel penable pwrite pready   | paddr pwdata prdata
//
// One request per cycle while the result is not stalled; a request passes
// through the input register, then the result register. State updates as a
// request leaves the input register. Reset clears positions, calibration state
// and the pipe. A stalled result holds; the input register keeps taking
// requests until it is also full, then in_stall rises.
`default_nettype none
`include "step_guider_position_and_calibration_macros.svh"

module step_guider_position_and_calibration #(
	parameter int POS_BITS = sgpc_pkg::POS_BITS_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [sgpc_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [sgpc_pkg::DATA_W-1:0]     pwdata,
	output logic      [sgpc_pkg::DATA_W-1:0]     prdata,
	output logic                                 pready,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      operation,
	input  wire logic [1:0]                      direction,
	input  wire logic [sgpc_pkg::AMT_W-1:0]      amount,
	input  wire logic                            normal_move,
	input  wire logic                            secondary_ready,
	input  wire logic                            position_valid,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [1:0]                      status,
	output logic      [sgpc_pkg::MAX_W-1:0]      steps_taken,
	output logic      [sgpc_pkg::POS_OUT_W-1:0]  x_position,
	output logic      [sgpc_pkg::POS_OUT_W-1:0]  y_position,
	output logic                                 move_north,
	output logic                                 move_south,
	output logic                                 move_east,
	output logic                                 move_west,
	output logic                                 calibrated,
	output logic      [1:0]                      leg_finished,
	output logic      [sgpc_pkg::CNT_W-1:0]      leg_iterations,
	output logic                                 offload_request
);
	import sgpc_pkg::*;

	cfg_t cfg;
	req_t req_s1;
	logic vld_s1;
	rsp_t rsp_c, rsp_s2;
	logic vld_s2;
	logic adv, acc;

	assign adv      = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && !adv;
	assign acc      = in_valid && !in_stall;

	sgpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sgpc_core #(.POS_BITS(POS_BITS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (rsp_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= acc || (vld_s1 && !adv);
			vld_s2 <= adv || (vld_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1.operation       <= op_t'(operation);
			req_s1.direction       <= dir_t'(direction);
			req_s1.amount          <= amount;
			req_s1.normal_move     <= normal_move;
			req_s1.secondary_ready <= secondary_ready;
			req_s1.position_valid  <= position_valid;
		end
		if (adv) begin
			rsp_s2 <= rsp_c;
		end
	end

	assign out_valid       = vld_s2;
	assign status          = rsp_s2.status;
	assign steps_taken     = rsp_s2.steps_taken;
	assign x_position      = rsp_s2.x_position;
	assign y_position      = rsp_s2.y_position;
	assign move_north      = rsp_s2.move_north;
	assign move_south      = rsp_s2.move_south;
	assign move_east       = rsp_s2.move_east;
	assign move_west       = rsp_s2.move_west;
	assign calibrated      = rsp_s2.calibrated;
	assign leg_finished    = rsp_s2.leg_finished;
	assign leg_iterations  = rsp_s2.leg_iterations;
	assign offload_request = rsp_s2.offload_request;

	`SGPC_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, in_stall, vld_s1 && vld_s2 && out_stall, "input stalled while pipe can drain")
	`SGPC_ASSERT_NXT(a_empty_out_fills, clk, arst_n, vld_s1 && !vld_s2, vld_s2, "request did not reach result register")
	`SGPC_ASSERT_NOW(a_limit_no_steps, clk, arst_n, vld_s2 && rsp_s2.status == ST_LIMIT, rsp_s2.steps_taken == '0, "refused move reports steps")
	`SGPC_ASSERT_NOW(a_west_alone, clk, arst_n, vld_s2 && rsp_s2.move_west, !rsp_s2.move_north && !rsp_s2.move_south && !rsp_s2.move_east, "west leg raised another flag")

endmodule

`default_nettype wire
